/* rtl/ppe_pkg.sv */
package ppe_pkg;
	localparam int MaxSegments = 16;
	localparam int MaxCoefficients = 6;
	localparam int FracBits = 16;
	localparam int SegW = $clog2(MaxSegments);
	localparam int CoefW = $clog2(MaxCoefficients);
	localparam int CoefDepth = MaxSegments * MaxCoefficients;
	localparam int CoefAddrW = $clog2(CoefDepth);
	localparam int CountW = $clog2(MaxSegments + 1);

	typedef enum logic [1:0] {
		ACT_BOUNDS = 2'd0,
		ACT_COEF   = 2'd1,
		ACT_EVAL   = 2'd2,
		ACT_NONE   = 2'd3
	} action_t;

	localparam logic signed [31:0] SMax = 32'sh7FFF_FFFF;
	localparam logic signed [31:0] SMin = 32'sh8000_0000;

	function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
		logic signed [31:0] r;
		if (v > 66'sd2147483647) r = SMax;
		else if (v < -66'sd2147483648) r = SMin;
		else r = v[31:0];
		return r;
	endfunction
endpackage

/* rtl/piecewise_polynomial_evaluator.sv */
// Piecewise polynomial evaluator, signed Q16.16, one shared 32x32 multiplier.
// Load items leave busy low, so they can be issued back to back.
// Evaluate hit at segment i with T Horner terms: a search that scans one segment a cycle,
// then a read, multiply and add per term, then one output state; a miss scans all n segments.
// Strobe rises as busy falls and carries value and found; busy is high for the whole evaluation.
// Reset clears count and bounds, then a pass clears all 96 coefficient words; no result stall.
module piecewise_polynomial_evaluator (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic        cfg_we,
	input  logic [4:0]  cfg_data,
	input  logic [1:0]  action,
	input  logic [3:0]  segment,
	input  logic [2:0]  coef_index,
	input  logic signed [31:0] coef_value,
	input  logic signed [31:0] start_value,
	input  logic signed [31:0] end_value,
	input  logic signed [31:0] time_req,
	input  logic [1:0]  derivative,
	input  logic        wrap,
	output logic        strobe,
	output logic signed [31:0] value,
	output logic        found
);
	import ppe_pkg::*;

	typedef enum logic [2:0] {
		S_CLEAR, S_IDLE, S_SEARCH, S_READ, S_MUL, S_ADD, S_DONE
	} state_t;

	state_t state_q;
	logic [4:0] count_q;
	logic signed [31:0] start_q [MaxSegments];
	logic signed [31:0] end_q [MaxSegments];
	logic signed [31:0] coef_mem [CoefDepth];
	logic signed [31:0] rd_q;
	logic [CoefAddrW-1:0] clr_q;
	logic signed [31:0] t_q, d_q, acc_q;
	logic signed [63:0] prod_q;
	logic [SegW-1:0] seg_q;
	logic [CountW-1:0] idx_q;
	logic [CoefW-1:0] k_q;
	logic [1:0] der_q;
	logic found_q;

	// Wrap fold: below zero take 1 + signed fraction; above one keep fraction.
	logic signed [31:0] t_fold;
	logic [31:0] mag;
	always_comb begin
		mag = -time_req;
		if (time_req < 0)
			t_fold = (32'sd1 <<< FracBits) - $signed({16'd0, mag[FracBits-1:0]});
		else if (time_req > (32'sd1 <<< FracBits))
			t_fold = $signed({16'd0, time_req[FracBits-1:0]});
		else
			t_fold = time_req;
	end

	logic [CountW-1:0] n_lim;
	assign n_lim = (count_q > 5'(MaxSegments)) ? CountW'(MaxSegments) : count_q[CountW-1:0];

	logic [SegW-1:0] idx_s;
	assign idx_s = idx_q[SegW-1:0];
	logic hit;
	assign hit = (t_q >= start_q[idx_s]) && (t_q <= end_q[idx_s]);
	logic signed [32:0] d_wide;
	assign d_wide = 33'(t_q) - 33'(start_q[idx_s]);

	// Derivative scaling k or k*(k-1), then Horner add with floor shift.
	logic signed [65:0] scaled, sum;
	logic [4:0] fac;
	logic signed [47:0] fl;
	always_comb begin
		unique case (der_q)
			2'd1: fac = 5'(k_q);
			2'd2: fac = 5'(k_q) * (5'(k_q) - 5'd1);
			default: fac = 5'd1;
		endcase
		scaled = 66'(rd_q) * $signed({61'd0, fac});
		fl = 48'(prod_q >>> FracBits);
		sum = 66'(fl) + 66'(sat32(scaled));
	end

	logic in_take;
	assign in_take = start && !busy;
	assign busy = (state_q != S_IDLE);

	logic [CoefAddrW-1:0] rd_addr;
	assign rd_addr = CoefAddrW'(seg_q * MaxCoefficients + k_q);
	logic [CoefAddrW-1:0] wr_addr;
	assign wr_addr = CoefAddrW'(segment * MaxCoefficients + coef_index);

	always_ff @(posedge clk) begin
		if (state_q == S_CLEAR) coef_mem[clr_q] <= '0;
		else if (in_take && action == ACT_COEF && coef_index < 3'(MaxCoefficients))
			coef_mem[wr_addr] <= coef_value;
		rd_q <= coef_mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			count_q <= '0;
			clr_q <= '0;
			strobe <= 1'b0;
			for (int i = 0; i < MaxSegments; i++) begin
				start_q[i] <= '0;
				end_q[i] <= '0;
			end
		end else begin
			strobe <= 1'b0;
			if (cfg_we) count_q <= cfg_data;
			unique case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == CoefAddrW'(CoefDepth - 1)) state_q <= S_IDLE;
				end
				S_IDLE: begin
					if (in_take) begin
						if (action == ACT_BOUNDS) begin
							start_q[segment] <= start_value;
							end_q[segment] <= end_value;
						end else if (action == ACT_EVAL) begin
							t_q <= wrap ? t_fold : time_req;
							der_q <= derivative;
							idx_q <= '0;
							found_q <= 1'b0;
							acc_q <= '0;
							state_q <= S_SEARCH;
						end
					end
				end
				S_SEARCH: begin
					// Scan one segment a cycle; first match wins.
					if (idx_q >= n_lim) begin
						state_q <= S_DONE;
					end else if (hit) begin
						found_q <= 1'b1;
						seg_q <= idx_s;
						d_q <= (d_wide > 33'sd2147483647) ? SMax : d_wide[31:0];
						k_q <= CoefW'(MaxCoefficients - 1);
						state_q <= (der_q == 2'd3) ? S_DONE : S_READ;
					end else begin
						idx_q <= idx_q + 1'b1;
					end
				end
				S_READ: begin
					// Coefficient read lands in rd_q; multiply the running sum.
					state_q <= S_MUL;
				end
				S_MUL: begin
					prod_q <= 64'(acc_q) * 64'(d_q);
					state_q <= S_ADD;
				end
				S_ADD: begin
					acc_q <= sat32(sum);
					if (k_q == CoefW'(der_q)) state_q <= S_DONE;
					else begin
						k_q <= k_q - 1'b1;
						state_q <= S_READ;
					end
				end
				S_DONE: begin
					strobe <= 1'b1;
					found <= found_q;
					value <= (found_q && der_q != 2'd3) ? acc_q : '0;
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule

/* bench/piecewise_polynomial_evaluator_test.sv */
module piecewise_polynomial_evaluator_test;
	import ppe_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	// One command as the bench sees it: every payload port of the block.
	typedef struct {
		action_t            act;
		logic [3:0]         seg;
		logic [2:0]         cidx;
		logic signed [31:0] cval;
		logic signed [31:0] lo;
		logic signed [31:0] hi;
		logic signed [31:0] t;
		logic [1:0]         der;
		logic               wrap;
	} command_t;

	typedef struct {
		logic signed [31:0] value;
		logic               found;
	} eval_result_t;

	localparam longint CycleLimit = 3_000_000;
	localparam int Settle = 120;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	logic cfg_we = 1'b0;
	logic [4:0] cfg_data = '0;
	logic [1:0] action = '0;
	logic [3:0] segment = '0;
	logic [2:0] coef_index = '0;
	logic signed [31:0] coef_value = '0;
	logic signed [31:0] start_value = '0;
	logic signed [31:0] end_value = '0;
	logic signed [31:0] time_req = '0;
	logic [1:0] derivative = '0;
	logic wrap = 1'b0;
	logic strobe;
	logic signed [31:0] value;
	logic found;

	command_t pending_cmds[$];
	eval_result_t expected_results[$];
	command_t cur;
	int err_count = 0;
	int sender_idle_pct = 0;
	longint cycle_count = 0;

	// Shadow copy of the segment table and the count register.
	logic signed [31:0] tbl_lo[MaxSegments];
	logic signed [31:0] tbl_hi[MaxSegments];
	logic signed [31:0] tbl_coef[CoefDepth];
	logic [4:0] tbl_count;

	piecewise_polynomial_evaluator u_top (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.cfg_we(cfg_we), .cfg_data(cfg_data),
		.action(action), .segment(segment), .coef_index(coef_index),
		.coef_value(coef_value), .start_value(start_value), .end_value(end_value),
		.time_req(time_req), .derivative(derivative), .wrap(wrap),
		.strobe(strobe), .value(value), .found(found)
	);

	always #5 clk = ~clk;

	function automatic longint clamp32(input longint v);
		if (v > 64'sd2147483647) return 64'sd2147483647;
		if (v < -64'sd2147483648) return -64'sd2147483648;
		return v;
	endfunction

	// Fold t into the unit period: negatives map to 1 + signed fraction,
	// values above 1.0 drop their integer part, 1.0 itself stays.
	function automatic longint fold_to_unit(input longint t);
		longint one, mag, ipart;
		one = longint'(1) <<< FracBits;
		if (t < 0) begin
			mag = -t;
			ipart = (mag >>> FracBits) <<< FracBits;
			return one - (mag - ipart);
		end
		if (t > one) begin
			ipart = (t >>> FracBits) <<< FracBits;
			return t - ipart;
		end
		return t;
	endfunction

	// Horner on the chosen derivative; product floored by the arithmetic shift.
	function automatic longint horner_at(input int s, input longint d, input int order);
		longint acc, c, f;
		acc = 0;
		for (int k = MaxCoefficients - 1; k >= order; k--) begin
			f = 1;
			if (order >= 1) f = f * k;
			if (order >= 2) f = f * (k - 1);
			c = clamp32(longint'(tbl_coef[s * MaxCoefficients + k]) * f);
			acc = clamp32(((acc * d) >>> FracBits) + c);
		end
		return acc;
	endfunction

	// Apply one accepted command to the shadow table; queue the result it causes.
	function automatic void evaluate_segment_table(input command_t c);
		eval_result_t r;
		longint t, d;
		int n;
		case (c.act)
			ACT_BOUNDS: begin
				tbl_lo[c.seg] = c.lo;
				tbl_hi[c.seg] = c.hi;
			end
			ACT_COEF: begin
				if (c.cidx < MaxCoefficients)
					tbl_coef[c.seg * MaxCoefficients + c.cidx] = c.cval;
			end
			ACT_EVAL: begin
				r.value = '0;
				r.found = 1'b0;
				t = longint'(c.t);
				if (c.wrap) t = fold_to_unit(t);
				n = (tbl_count > MaxSegments) ? MaxSegments : int'(tbl_count);
				for (int i = 0; i < n; i++) begin
					if (!r.found && t >= longint'(tbl_lo[i]) && t <= longint'(tbl_hi[i])) begin
						d = t - longint'(tbl_lo[i]);
						if (d > 64'sd2147483647) d = 64'sd2147483647;
						r.found = 1'b1;
						if (c.der <= 2) r.value = 32'(horner_at(i, d, int'(c.der)));
					end
				end
				expected_results.insert(expected_results.size(), r);
			end
			default: ;
		endcase
	endfunction

	// Driver: predict on acceptance, then hold, advance or idle.
	always @(posedge clk) begin
		logic launch;
		launch = 1'b0;
		if (cfg_we) tbl_count = cfg_data;
		if (start && !busy) evaluate_segment_table(cur);
		if (!start || !busy) begin
			if (pending_cmds.size() > 0 && $urandom_range(99) >= sender_idle_pct) begin
				cur = pending_cmds.pop_front();
				launch = 1'b1;
				action <= cur.act;
				segment <= cur.seg;
				coef_index <= cur.cidx;
				coef_value <= cur.cval;
				start_value <= cur.lo;
				end_value <= cur.hi;
				time_req <= cur.t;
				derivative <= cur.der;
				wrap <= cur.wrap;
			end
			start <= launch;
		end
	end

	// Monitor: every strobe must match the oldest outstanding evaluation.
	always @(posedge clk) begin
		eval_result_t e;
		if (arst_n && strobe) begin
			if (expected_results.size() == 0) begin
				$error("unexpected result value=%0d found=%0b", value, found);
				err_count++;
			end else begin
				e = expected_results.pop_front();
				if (value !== e.value) begin
					$error("value: expected %0d, actual %0d", e.value, value);
					err_count++;
				end
				if (found !== e.found) begin
					$error("found: expected %0b, actual %0b", e.found, found);
					err_count++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CycleLimit) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	task automatic drain();
		while (pending_cmds.size() > 0 || start || expected_results.size() > 0)
			@(posedge clk);
		// load items leave no trace in the result queue; let the block settle
		repeat (Settle) @(posedge clk);
	endtask

	task automatic write_count(input logic [4:0] v);
		drain();
		cfg_we <= 1'b1;
		cfg_data <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	function automatic void queue_cmd(input command_t c);
		pending_cmds.insert(pending_cmds.size(), c);
	endfunction

	function automatic command_t blank_cmd(input action_t a);
		command_t c;
		c.act = a;
		c.seg = 4'($urandom_range(15));
		c.cidx = 3'($urandom_range(5));
		c.cval = $urandom;
		c.lo = $urandom;
		c.hi = $urandom;
		c.t = $urandom;
		c.der = 2'($urandom_range(3));
		c.wrap = 1'($urandom_range(1));
		return c;
	endfunction

	function automatic logic signed [31:0] small_signed(input int span);
		return 32'($signed($urandom_range(2 * span)) - span);
	endfunction

	// Mostly well-formed: narrow segments, modest coefficients, queries that land
	// inside a loaded segment; the rest is full-range noise and ignored actions.
	function automatic command_t random_cmd();
		command_t c;
		int pick, s;
		longint lo, hi;
		pick = $urandom_range(99);
		if (pick < 25) begin
			c = blank_cmd(ACT_BOUNDS);
			if ($urandom_range(4) != 0) begin
				c.lo = small_signed(1 << 18);
				c.hi = c.lo + 32'($urandom_range(1 << 17));
			end
		end else if (pick < 55) begin
			c = blank_cmd(ACT_COEF);
			if ($urandom_range(9) == 0) c.cidx = 3'($urandom_range(7, 6));
			if ($urandom_range(3) != 0) c.cval = small_signed(1 << 17);
		end else if (pick < 95) begin
			c = blank_cmd(ACT_EVAL);
			if ($urandom_range(9) < 6) begin
				s = $urandom_range(15);
				lo = tbl_lo[s];
				hi = tbl_hi[s];
				if (hi >= lo && hi - lo < 64'sd4000000000)
					c.t = 32'(lo + longint'($urandom_range(32'(hi - lo))));
				c.wrap = 1'b0;
			end
		end else begin
			c = blank_cmd(ACT_NONE);
		end
		return c;
	endfunction

	function automatic void push_bounds(input int s, input logic signed [31:0] lo,
			input logic signed [31:0] hi);
		command_t c;
		c = blank_cmd(ACT_BOUNDS);
		c.seg = 4'(s);
		c.lo = lo;
		c.hi = hi;
		queue_cmd(c);
	endfunction

	function automatic void push_coef(input int s, input int k, input logic signed [31:0] v);
		command_t c;
		c = blank_cmd(ACT_COEF);
		c.seg = 4'(s);
		c.cidx = 3'(k);
		c.cval = v;
		queue_cmd(c);
	endfunction

	function automatic void push_eval(input logic signed [31:0] t, input int der,
			input logic w);
		command_t c;
		c = blank_cmd(ACT_EVAL);
		c.t = t;
		c.der = 2'(der);
		c.wrap = w;
		queue_cmd(c);
	endfunction

	initial begin
		command_t c;
		int idle_mix[4];
		logic [4:0] count_mix[4];
		idle_mix = '{0, 50, 0, 13};
		count_mix = '{5'd31, 5'd0, 5'd7, 5'd16};
		for (int i = 0; i < MaxSegments; i++) begin
			tbl_lo[i] = '0;
			tbl_hi[i] = '0;
		end
		for (int i = 0; i < CoefDepth; i++) tbl_coef[i] = '0;
		tbl_count = '0;

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		// Directed: unit segment with full-scale coefficients, extreme bounds,
		// inverted segment, ignored indexes and actions, every derivative, wrap.
		write_count(5'd16);
		push_eval(32'sh0000_8000, 0, 1'b0);       // zero-width segments at 0: no hit
		push_bounds(0, 32'sh0001_0000, 32'sh0000_0000); // inverted, never matches
		push_bounds(1, 32'sh0000_0000, 32'sh0001_0000);
		push_bounds(15, 32'sh8000_0000, 32'sh7FFF_FFFF);
		for (int k = 0; k < MaxCoefficients; k++)
			push_coef(1, k, (k % 2) ? 32'sh7FFF_FFFF : 32'sh8000_0000);
		push_coef(1, 6, 32'sh1234_5678);          // index beyond the table, ignored
		push_coef(15, 7, 32'sh7FFF_FFFF);         // ignored as well
		push_coef(15, 1, 32'sh0001_0000);
		for (int dv = 0; dv < 4; dv++) push_eval(32'sh0000_C000, dv, 1'b0);
		push_eval(32'sh8000_0000, 0, 1'b0);       // zero offset on the wide segment
		push_eval(32'sh7FFF_FFFF, 1, 1'b0);       // offset saturates
		push_eval(32'shFFFE_4000, 2, 1'b1);       // wrap below zero
		push_eval(32'sh0003_4000, 0, 1'b1);       // wrap above one
		push_eval(32'sh0001_0000, 1, 1'b1);       // exactly one stays
		push_eval(32'sh8000_0000, 0, 1'b1);
		c = blank_cmd(ACT_NONE);
		queue_cmd(c);

		for (int p = 0; p < 4; p++) begin
			write_count(count_mix[p]);
			sender_idle_pct = idle_mix[p];
			for (int n = 0; n < 250; n++) queue_cmd(random_cmd());
		end

		drain();
		if (err_count == 0 && expected_results.size() == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end
endmodule

/* filelist.f */
rtl/ppe_pkg.sv
rtl/piecewise_polynomial_evaluator.sv
bench/piecewise_polynomial_evaluator_test.sv
